// ----- rtl/core/sat_pkg.sv -----
package sat_pkg;

  localparam int SUM_W = 37;
  localparam int CFG_W = 11;
  localparam int DIM_W = 16;
  localparam int IDX_W = 1;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 11'd1024;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic col_zero;
    logic row_zero;
  } pos_flags_t;

endpackage

// ----- rtl/core/sat_pixel_if.sv -----
interface sat_pixel_if #(
  parameter int VALUE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

// ----- rtl/core/sat_result_if.sv -----
interface sat_result_if;
  logic                valid;
  logic                ready;
  sat_pkg::sum_t       integral_sum;
  logic                row_end;
  logic                frame_end;

  modport source (output valid, output integral_sum, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input integral_sum, input row_end, input frame_end,
                output ready);
endinterface

// ----- rtl/core/sat_ram.sv -----
module sat_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/sat_position.sv -----
module sat_position #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic [sat_pkg::CFG_W-1:0]      frame_width,
  input  logic [sat_pkg::CFG_W-1:0]      frame_height,
  output logic [$clog2(MAX_COLUMNS)-1:0] col,
  output sat_pkg::pos_flags_t            flags
);
  import sat_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  logic [ROW_W-1:0] row;
  logic [DIM_W-1:0] width_eff;
  logic [DIM_W-1:0] height_eff;
  logic [DIM_W-1:0] col_inc;
  logic [DIM_W-1:0] row_inc;

  always_comb begin
    if (frame_width == '0) begin
      width_eff = DIM_W'(1);
    end else if (DIM_W'(frame_width) > DIM_W'(MAX_COLUMNS)) begin
      width_eff = DIM_W'(MAX_COLUMNS);
    end else begin
      width_eff = DIM_W'(frame_width);
    end
    if (frame_height == '0) begin
      height_eff = DIM_W'(1);
    end else if (DIM_W'(frame_height) > DIM_W'(MAX_ROWS)) begin
      height_eff = DIM_W'(MAX_ROWS);
    end else begin
      height_eff = DIM_W'(frame_height);
    end
    col_inc = DIM_W'(col) + DIM_W'(1);
    row_inc = DIM_W'(row) + DIM_W'(1);
    flags.row_end   = col_inc >= width_eff;
    flags.frame_end = flags.row_end && (row_inc >= height_eff);
    flags.col_zero  = col == '0;
    flags.row_zero  = row == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (flags.frame_end) begin
        col <= '0;
        row <= '0;
      end else if (flags.row_end) begin
        col <= '0;
        row <= ROW_W'(row_inc);
      end else begin
        col <= COL_W'(col_inc);
      end
    end
  end

endmodule

// ----- rtl/core/summed_area_table.sv -----
// Path: an accepted pixel beat is registered in stage one and then in the result register, where its
// result beat waits to be taken; a stalled result side holds the beat back.
// Throughput: one beat per cycle unless the result side stalls; each beat does one line-buffer
// read at accept and one write-back as it leaves stage one, forwarding when both hit the same column.
// Reset: synchronous; the line buffer is zeroed by a pass over all MAX_COLUMNS addresses,
// during which pixel ready stays low. Configuration writes are taken at any time.
module summed_area_table #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int VALUE_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [sat_pkg::IDX_W-1:0] cfg_index,
  input  logic [sat_pkg::CFG_W-1:0] cfg_data,
  sat_pixel_if.sink                 pixel,
  sat_result_if.source              result
);
  import sat_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);

  logic [CFG_W-1:0]      frame_width;
  logic [CFG_W-1:0]      frame_height;
  logic                  clearing;
  logic [COL_W-1:0]      clr_addr;
  logic                  accept;
  logic [COL_W-1:0]      pos_col;
  pos_flags_t            pos_flags;

  logic                  s1_valid;
  logic                  s1_adv;
  logic [COL_W-1:0]      s1_col;
  pos_flags_t            s1_flags;
  logic [VALUE_BITS-1:0] s1_value;
  logic                  s1_fwd;
  sum_t                  s1_fwd_data;

  sum_t                  left_sum;
  sum_t                  diagonal_sum;
  sum_t                  ram_rdata;
  sum_t                  above;
  sum_t                  left;
  sum_t                  diag;
  sum_t                  value_ext;
  sum_t                  sum;

  logic                  ram_we;
  logic [COL_W-1:0]      ram_waddr;
  sum_t                  ram_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_DIM_RESET;
      frame_height <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == COL_W'(MAX_COLUMNS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign s1_adv      = s1_valid && (!result.valid || result.ready);
  assign pixel.ready = !clearing && (!s1_valid || s1_adv);
  assign accept      = pixel.valid && pixel.ready;

  sat_position #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_position (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .col          (pos_col),
    .flags        (pos_flags)
  );

  assign ram_we    = clearing || s1_adv;
  assign ram_waddr = clearing ? clr_addr : s1_col;
  assign ram_wdata = clearing ? '0 : sum;

  sat_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (pos_col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col      <= pos_col;
      s1_flags    <= pos_flags;
      s1_value    <= pixel.pixel_value;
      s1_fwd      <= s1_adv && (s1_col == pos_col);
      s1_fwd_data <= sum;
    end
  end

  always_comb begin
    value_ext = {{(SUM_W - VALUE_BITS){s1_value[VALUE_BITS-1]}}, s1_value};
    if (s1_flags.row_zero) begin
      above = '0;
    end else if (s1_fwd) begin
      above = s1_fwd_data;
    end else begin
      above = ram_rdata;
    end
    left = s1_flags.col_zero ? '0 : left_sum;
    diag = (s1_flags.col_zero || s1_flags.row_zero) ? '0 : diagonal_sum;
    sum  = value_ext + above + left - diag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sum     <= '0;
      diagonal_sum <= '0;
    end else if (s1_adv) begin
      left_sum     <= sum;
      diagonal_sum <= above;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.integral_sum <= sum;
      result.row_end      <= s1_flags.row_end;
      result.frame_end    <= s1_flags.frame_end;
    end
  end

`ifndef SYNTH
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pixel.ready)
    else $error("pixel accepted during line buffer clear");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_end |-> result.row_end)
    else $error("frame end without row end");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (rst)
    accept && s1_adv && (s1_col == pos_col) |=> s1_fwd && s1_col == $past(pos_col))
    else $error("forward not armed on same-column hit");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_col) && $stable(s1_fwd))
    else $error("stage one changed while stalled");
`endif

endmodule

// ----- sim/summed_area_table_checker.sv -----
module summed_area_table_checker #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  parameter int VALUE_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [sat_pkg::IDX_W-1:0] cfg_index,
  input  logic [sat_pkg::CFG_W-1:0] cfg_data,
  sat_pixel_if                      pixel,
  sat_result_if                     result,
  output int                        pending,
  output int                        errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import sat_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  typedef logic signed [VALUE_BITS-1:0] pixel_t;

  typedef struct packed {
    sum_t integral_sum;
    logic row_end;
    logic frame_end;
  } integral_point_t;

  sum_t             line_sums [MAX_COLUMNS];
  sum_t             left_sum;
  sum_t             diag_sum;
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  integral_point_t  awaited_sums [$];
  int               result_beats;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] raw, input int unsigned lim);
    if (raw == '0) return 1;
    if (32'(raw) > lim) return lim;
    return 32'(raw);
  endfunction

  task automatic predict_integral(input pixel_t value, output integral_point_t point);
    int unsigned span_w;
    int unsigned span_h;
    sum_t        above;
    sum_t        left;
    sum_t        diag;
    sum_t        total;
    span_w = clamp_dim(width_reg, MAX_COLUMNS);
    span_h = clamp_dim(height_reg, MAX_ROWS);
    above  = (row_pos != '0) ? line_sums[col_pos] : '0;
    left   = (col_pos != '0) ? left_sum : '0;
    diag   = (col_pos != '0 && row_pos != '0) ? diag_sum : '0;
    total  = sum_t'(value) + above + left - diag;
    line_sums[col_pos] = total;
    left_sum = total;
    diag_sum = above;
    point.integral_sum = total;
    point.row_end      = (int'(col_pos) + 1 >= span_w);
    point.frame_end    = point.row_end && (int'(row_pos) + 1 >= span_h);
    if (point.frame_end) begin
      col_pos = '0;
      row_pos = '0;
    end else if (point.row_end) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    integral_point_t point;
    integral_point_t want;
    if (rst) begin
      foreach (line_sums[i]) line_sums[i] = '0;
      left_sum     = '0;
      diag_sum     = '0;
      col_pos      = '0;
      row_pos      = '0;
      width_reg    = CFG_DIM_RESET;
      height_reg   = CFG_DIM_RESET;
      result_beats = 0;
      errors       = 0;
      awaited_sums.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_FRAME_HEIGHT) height_reg = cfg_data;
      end
      if (pixel.valid && pixel.ready) begin
        predict_integral(pixel.pixel_value, point);
        awaited_sums.push_back(point);
      end
      if (result.valid && result.ready) begin
        if (awaited_sums.size() == 0) begin
          report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                    result_beats));
        end else begin
          want = awaited_sums.pop_front();
          if (result.integral_sum !== want.integral_sum)
            report_mismatch($sformatf("beat %0d integral_sum %0d, expected %0d",
                                      result_beats, result.integral_sum, want.integral_sum));
          if (result.row_end !== want.row_end)
            report_mismatch($sformatf("beat %0d row_end %b, expected %b",
                                      result_beats, result.row_end, want.row_end));
          if (result.frame_end !== want.frame_end)
            report_mismatch($sformatf("beat %0d frame_end %b, expected %b",
                                      result_beats, result.frame_end, want.frame_end));
        end
        result_beats++;
      end
    end
    pending = awaited_sums.size();
  end

endmodule

// ----- sim/summed_area_table_tb.sv -----
module summed_area_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sat_pkg::*;

  localparam int MAX_COLUMNS    = 1024;
  localparam int MAX_ROWS       = 1024;
  localparam int VALUE_BITS     = 16;
  localparam int RANDOM_ITEMS   = 60;
  localparam int LONG_ROW_ITEMS = 1030;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic signed [VALUE_BITS-1:0] pixel_t;

  localparam pixel_t PIX_MAX = 16'sh7FFF;
  localparam pixel_t PIX_MIN = 16'sh8000;

  logic             clk;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;
  int               pending;
  int               errors;
  int               idle_cycles;
  bit               tx_busy;
  bit               rx_busy;

  sat_pixel_if #(.VALUE_BITS(VALUE_BITS)) pixel_bus ();
  sat_result_if result_bus ();

  summed_area_table #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixel    (pixel_bus),
    .result   (result_bus)
  );

  summed_area_table_checker #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .VALUE_BITS (VALUE_BITS)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixel    (pixel_bus),
    .result   (result_bus),
    .pending  (pending),
    .errors   (errors)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || (pixel_bus.valid && pixel_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("summed_area_table: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    result_bus.ready = 1'b0;
    rx_busy = 1'b1;
    @(negedge clk iff !rst);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_busy = !rx_busy;
      stall = rx_busy ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      @(negedge clk);
    end
  end

  function automatic pixel_t pick_pixel();
    case ($urandom_range(0, 7))
      0: return PIX_MAX;
      1: return PIX_MIN;
      2, 3: return pixel_t'(int'($urandom_range(0, 16)) - 8);
      default: return pixel_t'($urandom);
    endcase
  endfunction

  task automatic pick_dim(input int small_max, input int lim, output int span,
                          output logic [CFG_W-1:0] code);
    case ($urandom_range(0, 9))
      0: begin
        span = 1;
        code = '0;
      end
      1: begin
        span = lim;
        code = CFG_W'($urandom_range(lim, 2 ** CFG_W - 1));
      end
      default: begin
        span = $urandom_range(1, small_max);
        code = CFG_W'(span);
      end
    endcase
  endtask

  task automatic send_pixel(input pixel_t value);
    int gap;
    gap = tx_busy ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      pixel_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_bus.valid       <= 1'b1;
    pixel_bus.pixel_value <= value;
    do @(posedge clk); while (!pixel_bus.ready);
    @(negedge clk);
  endtask

  task automatic settle_pipeline();
    pixel_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_dims(input bit set_w, input bit set_h,
                              input logic [CFG_W-1:0] w_code, input logic [CFG_W-1:0] h_code);
    settle_pipeline();
    if (set_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_WIDTH;
      cfg_data  <= w_code;
      @(negedge clk);
    end
    if (set_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_data  <= h_code;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int               sent_items;
    int               beats;
    int               coin;
    int               frame_cols;
    int               frame_rows;
    int               new_w;
    int               new_h;
    logic [CFG_W-1:0] w_code;
    logic [CFG_W-1:0] h_code;
    pixel_bus.valid       = 1'b0;
    pixel_bus.pixel_value = '0;
    tx_busy = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
    send_pixel(pixel_t'(-1));
    // shrink the row while the position already lies past the new bound
    program_dims(1'b1, 1'b0, CFG_W'(2), '0);
    send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
    send_pixel(pixel_t'(1));
    program_dims(1'b0, 1'b1, '0, CFG_W'(1));
    send_pixel('0);
    send_pixel(PIX_MAX);
    // zero sizes act as one: every beat closes a frame
    program_dims(1'b1, 1'b1, '0, '0);
    send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
    send_pixel('0);
    send_pixel(pixel_t'(-1));
    send_pixel(pixel_t'(1));

    // oversized codes clamp to the maximum: one full row plus the start of the next
    program_dims(1'b1, 1'b1, '1, '1);
    tx_busy = 1'b0;
    repeat (LONG_ROW_ITEMS) send_pixel(pick_pixel());
    frame_cols = MAX_COLUMNS;
    frame_rows = MAX_ROWS;

    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      coin = $urandom_range(0, 5);
      pick_dim(9, MAX_COLUMNS, new_w, w_code);
      pick_dim(6, MAX_ROWS, new_h, h_code);
      program_dims(coin != 1, coin != 2, w_code, h_code);
      if (coin != 1) frame_cols = new_w;
      if (coin != 2) frame_rows = new_h;
      tx_busy = ($urandom_range(0, 3) != 0);
      if (frame_cols * frame_rows <= 64) begin
        beats = frame_cols * frame_rows * $urandom_range(1, 3);
        if ($urandom_range(0, 2) == 0) beats += $urandom_range(1, frame_cols * frame_rows);
      end else begin
        beats = $urandom_range(1, 40);
      end
      repeat (beats) send_pixel(pick_pixel());
      sent_items += beats;
    end

    settle_pipeline();
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("summed_area_table: match");
    end else begin
      $display("summed_area_table: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sat_pkg.sv
rtl/core/sat_pixel_if.sv
rtl/core/sat_result_if.sv
rtl/core/sat_ram.sv
rtl/core/sat_position.sv
rtl/core/summed_area_table.sv
sim/summed_area_table_checker.sv
sim/summed_area_table_tb.sv
